// ===== rtl/kpq_pkg.sv =====
// ----------------------------------------------------------------------------
// kpq_pkg: shared types and codes of the keyed priority queue
// Entry layout, command and status codes, cell control word and the
// ranking function used by every cell of the sorted chain.
// ----------------------------------------------------------------------------
`default_nettype none

package kpq_pkg;

  localparam int KPQ_CAPACITY = 64;

  // command codes on in_command
  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_PEEK = 2'd1,
    CMD_POP  = 2'd2
  } cmd_t;

  // status codes on out_status
  typedef enum logic [1:0] {
    ST_VALID = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // one stored entry
  typedef struct packed {
    logic [15:0] score;
    logic [15:0] ident;
    logic [15:0] tag;
  } entry_t;

  // what every cell does on the current edge
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_PUSH = 2'd1,
    CELL_POP  = 2'd2
  } cell_op_t;

  // control word broadcast along the chain
  typedef struct packed {
    cell_op_t op;
    entry_t   entry;
  } cell_ctrl_t;

  // true when x must sit strictly ahead of y
  function automatic logic ranks_above(entry_t x, entry_t y);
    logic res;
    if (x.score != y.score) begin
      res = (x.score > y.score);
    end else begin
      res = (x.ident < y.ident);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/kpq_cell.sv =====
// ----------------------------------------------------------------------------
// kpq_cell: one slot of the sorted chain
// Holds one entry and its valid bit. On a push it keeps its entry, takes
// the new one or takes its left neighbor's; on a pop it takes its right
// neighbor's.
// ----------------------------------------------------------------------------
`default_nettype none

module kpq_cell
  import kpq_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  cell_ctrl_t ctrl_i,
  input  entry_t     left_entry_i,
  input  wire        left_valid_i,
  input  wire        left_above_i,
  input  entry_t     right_entry_i,
  input  wire        right_valid_i,
  output entry_t     entry_o,
  output logic       valid_o,
  output logic       above_o
);

  entry_t entry_r, entry_nxt;
  logic   valid_r, valid_nxt;

  // new entry goes ahead of this slot (an empty slot is worse than anything)
  assign above_o = !valid_r || ranks_above(ctrl_i.entry, entry_r);

  // slot update
  always_comb begin
    entry_nxt = entry_r;
    valid_nxt = valid_r;
    case (ctrl_i.op)
      CELL_PUSH: begin
        if (left_above_i) begin
          entry_nxt = left_entry_i;
          valid_nxt = left_valid_i;
        end else if (above_o) begin
          entry_nxt = ctrl_i.entry;
          valid_nxt = 1'b1;
        end
      end
      CELL_POP: begin
        entry_nxt = right_entry_i;
        valid_nxt = right_valid_i;
      end
      default: begin
        entry_nxt = entry_r;
        valid_nxt = valid_r;
      end
    endcase
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;
  assign valid_o = valid_r;

endmodule

`default_nettype wire

// ===== rtl/keyed_priority_queue.sv =====
// ----------------------------------------------------------------------------
// keyed_priority_queue: bounded max-priority queue with id tie-break
// A chain of CAPACITY cells kept sorted best first. Push, peek and pop
// each return one result with the best entry after the command.
// ----------------------------------------------------------------------------
//  channel   ports                              transfer
//  command   start, busy, in_*                  start && !busy
//  result    out_valid, out_*                   out_valid, one cycle
//
//  An accepted command updates every cell on the accepting edge; the result
//  is on out_* in the next cycle, while busy is high, so the result does not
//  wait on the length of the chain. The chain needs only the accepting
//  edge; busy is held over the result cycle, so no command is taken then.
//  Reset clears all cell valid bits at once; the queue is empty after it.
//  The receiver cannot stall: each result stands for one cycle only.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_priority_queue
  import kpq_pkg::*;
#(
  parameter int CAPACITY = KPQ_CAPACITY
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  in_command,
  input  wire  [15:0] in_score,
  input  wire  [15:0] in_ident,
  input  wire  [15:0] in_tag,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_best_score,
  output logic [15:0] out_best_ident,
  output logic [15:0] out_best_tag
);

  logic          accept;
  cell_ctrl_t    ctrl;
  entry_t        cell_entry [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_above;
  logic          full;
  logic          pending_r, pending_nxt;
  logic          dropped_r, dropped_nxt;

  assign accept = start && !busy;
  assign full   = cell_valid[CAPACITY-1];

  // command decode into the chain's control word
  always_comb begin
    ctrl.entry = '{score: in_score, ident: in_ident, tag: in_tag};
    ctrl.op    = CELL_HOLD;
    dropped_nxt = 1'b0;
    if (accept) begin
      case (in_command)
        CMD_PUSH: begin
          if (full) begin
            dropped_nxt = 1'b1;
          end else begin
            ctrl.op = CELL_PUSH;
          end
        end
        CMD_POP: begin
          ctrl.op = CELL_POP;
        end
        default: begin
          ctrl.op = CELL_HOLD;
        end
      endcase
    end
  end

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_entry, right_entry;
    logic   left_valid, left_above, right_valid;

    if (i == 0) begin : g_head
      assign left_entry = '0;
      assign left_valid = 1'b1;
      assign left_above = 1'b0;
    end else begin : g_body
      assign left_entry = cell_entry[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_above = cell_above[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
      assign right_valid = cell_valid[i+1];
    end

    kpq_cell u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctrl_i        (ctrl),
      .left_entry_i  (left_entry),
      .left_valid_i  (left_valid),
      .left_above_i  (left_above),
      .right_entry_i (right_entry),
      .right_valid_i (right_valid),
      .entry_o       (cell_entry[i]),
      .valid_o       (cell_valid[i]),
      .above_o       (cell_above[i])
    );
  end

  // result sequencing
  assign pending_nxt = accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      dropped_r <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  assign busy      = pending_r;
  assign out_valid = pending_r;

  // result fields from the head cell
  always_comb begin
    if (!cell_valid[0]) begin
      out_status     = ST_EMPTY;
      out_best_score = '0;
      out_best_ident = '0;
      out_best_tag   = '0;
    end else begin
      out_status     = dropped_r ? ST_FULL : ST_VALID;
      out_best_score = cell_entry[0].score;
      out_best_ident = cell_entry[0].ident;
      out_best_tag   = cell_entry[0].tag;
    end
  end

`ifndef NO_ASSERTIONS
  // every accepted command yields a result in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n) accept |=> out_valid)
    else $error("result missing after accepted command");

  // a result stands for one cycle only
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // occupied cells form a prefix of the chain
  assert property (@(posedge clk) disable iff (!rst_n)
    (cell_valid & (cell_valid + 1'b1)) == '0)
    else $error("hole in the cell chain");

  // a dropped push only happens on a full chain
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> full)
    else $error("push dropped while not full");

  // head is never outranked by the second cell
  assert property (@(posedge clk) disable iff (!rst_n)
    cell_valid[1] |-> !ranks_above(cell_entry[1], cell_entry[0]))
    else $error("chain order broken at head");
`endif

endmodule

`default_nettype wire
